@@ sv/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes for the sorted timer queue: request codes, result
// kinds, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stq_pkg;

    // Field widths fixed by the interface
    localparam int TimeW  = 48;
    localparam int TmoW   = 31;
    localparam int OwnerW = 8;
    localparam int TagW   = 16;

    // Request codes (code 3 carries no meaning and is dropped)
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_EXEC   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_FIRED  = 2'd2,
        KIND_WAIT   = 2'd3
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic  load;       // capture request fields
        logic  insert;     // insert new timer in order
        logic  grab_match; // register owner/tag match vector
        logic  remove;     // remove first matching entry
        logic  pop;        // remove head entry
        logic  emit;       // load output register
        t_kind kind;
        logic  status;
        logic  last;
    } t_stq_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic full;       // every slot holds a timer
        logic any_match;  // registered match vector is non-empty
        logic head_valid; // slot 0 holds a timer
        logic head_due;   // slot 0 expiry is at or before now
    } t_stq_stat;

endpackage

@@ sv/stq_ctrl.sv @@
// ----------------------------------------------------------------------------
// stq_ctrl
// Request sequencer: accepts one request at a time and steps the datapath
// through insert, cancel search/remove, or the fire-then-report loop.
// ----------------------------------------------------------------------------
module stq_ctrl
    import stq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_req_type,
    input  t_stq_stat  i_stat,
    output logic       o_in_stall,
    output t_stq_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ADD    = 5'b00010,
        S_MATCH  = 5'b00100,
        S_CANCEL = 5'b01000,
        S_EXEC   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    // New request only when idle
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.kind = KIND_ADD;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    case (i_req_type)
                        REQ_ADD:    n_state = S_ADD;
                        REQ_CANCEL: n_state = S_MATCH;
                        REQ_EXEC:   n_state = S_EXEC;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_ADD;
                    o_cmd.status = i_stat.full ? ST_FAIL : ST_OK;
                    o_cmd.insert = !i_stat.full;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_MATCH: begin
                o_cmd.grab_match = 1'b1;
                n_state          = S_CANCEL;
            end
            S_CANCEL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_CANCEL;
                    o_cmd.status = i_stat.any_match ? ST_OK : ST_FAIL;
                    o_cmd.remove = i_stat.any_match;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.head_valid && i_stat.head_due) begin
                        o_cmd.kind = KIND_FIRED;
                        o_cmd.pop  = 1'b1;
                    end else begin
                        o_cmd.kind = KIND_WAIT;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A meaningful request always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type != REQ_UNUSED)) |=> (r_state != S_IDLE))
        else $error("request accepted but controller stayed idle");

    // A result flagged last always returns the controller to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("final result did not return controller to idle");

endmodule

@@ sv/stq_dpath.sv @@
// ----------------------------------------------------------------------------
// stq_dpath
// Row of timer cells kept sorted by expiry, plus request and output
// registers. Each cell decides its next value from itself and its neighbors.
// ----------------------------------------------------------------------------
module stq_dpath
    import stq_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stq_cmd          i_cmd,
    output t_stq_stat         o_stat,
    input  logic [TimeW-1:0]  i_now_ms,
    input  logic [TmoW-1:0]   i_timeout_ms,
    input  logic [OwnerW-1:0] i_owner_handle,
    input  logic [TagW-1:0]   i_timer_tag,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [1:0]        o_result_kind,
    output logic              o_status,
    output logic [OwnerW-1:0] o_fired_owner,
    output logic [TagW-1:0]   o_fired_tag,
    output logic [TimeW-1:0]  o_wait_ms,
    output logic              o_last
);

    // Request registers
    logic [TimeW-1:0]  r_now;
    logic [TimeW-1:0]  r_new_exp;
    logic [OwnerW-1:0] r_owner;
    logic [TagW-1:0]   r_tag;
    logic [TimeW:0]    w_sum;

    // Cell row
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [TimeW-1:0]       r_exp   [TABLE_DEPTH];
    logic [TimeW-1:0]       n_exp   [TABLE_DEPTH];
    logic [OwnerW-1:0]      r_own   [TABLE_DEPTH];
    logic [OwnerW-1:0]      n_own   [TABLE_DEPTH];
    logic [TagW-1:0]        r_tg    [TABLE_DEPTH];
    logic [TagW-1:0]        n_tg    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_match;
    logic [TABLE_DEPTH-1:0] w_match;
    logic [TABLE_DEPTH-1:0] w_le;
    logic [TABLE_DEPTH-1:0] w_pre;
    logic [TABLE_DEPTH-1:0] w_shift;

    // Output register
    logic              r_out_valid;
    t_kind             r_kind;
    logic              r_status;
    logic [OwnerW-1:0] r_fowner;
    logic [TagW-1:0]   r_ftag;
    logic [TimeW-1:0]  r_wait;
    logic              r_last;
    logic [TimeW-1:0]  w_head_wait;

    // Saturating expiry for add
    assign w_sum = {1'b0, i_now_ms} + {{(TimeW + 1 - TmoW){1'b0}}, i_timeout_ms};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now     <= i_now_ms;
            r_new_exp <= w_sum[TimeW] ? {TimeW{1'b1}} : w_sum[TimeW-1:0];
            r_owner   <= i_owner_handle;
            r_tag     <= i_timer_tag;
        end
    end

    // Per-cell compares: insert position and cancel match
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_le[i]    = r_valid[i] && (r_exp[i] <= r_new_exp);
            w_match[i] = r_valid[i] && (r_own[i] == r_owner) && (r_tg[i] == r_tag);
        end
    end

    // Prefix OR of matches: every cell at or above the first match shifts down
    always_comb begin
        w_pre = r_match;
        for (int k = 1; k < TABLE_DEPTH; k = k * 2) begin
            w_pre = w_pre | (w_pre << k);
        end
    end

    assign w_shift = i_cmd.pop    ? {TABLE_DEPTH{1'b1}} :
                     i_cmd.remove ? w_pre : {TABLE_DEPTH{1'b0}};

    // Cell next values
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic              w_up_valid;
        logic [TimeW-1:0]  w_up_exp;
        logic [OwnerW-1:0] w_up_own;
        logic [TagW-1:0]   w_up_tg;
        logic              w_lo_le;
        logic              w_lo_valid;
        logic [TimeW-1:0]  w_lo_exp;
        logic [OwnerW-1:0] w_lo_own;
        logic [TagW-1:0]   w_lo_tg;

        if (g == TABLE_DEPTH - 1) begin : g_top
            assign w_up_valid = 1'b0;
            assign w_up_exp   = r_exp[g];
            assign w_up_own   = r_own[g];
            assign w_up_tg    = r_tg[g];
        end else begin : g_mid
            assign w_up_valid = r_valid[g+1];
            assign w_up_exp   = r_exp[g+1];
            assign w_up_own   = r_own[g+1];
            assign w_up_tg    = r_tg[g+1];
        end

        if (g == 0) begin : g_bot
            assign w_lo_le    = 1'b1;
            assign w_lo_valid = 1'b1;
            assign w_lo_exp   = r_new_exp;
            assign w_lo_own   = r_owner;
            assign w_lo_tg    = r_tag;
        end else begin : g_upper
            assign w_lo_le    = w_le[g-1];
            assign w_lo_valid = r_valid[g-1];
            assign w_lo_exp   = r_exp[g-1];
            assign w_lo_own   = r_own[g-1];
            assign w_lo_tg    = r_tg[g-1];
        end

        always_comb begin
            n_valid[g] = r_valid[g];
            n_exp[g]   = r_exp[g];
            n_own[g]   = r_own[g];
            n_tg[g]    = r_tg[g];
            if (w_shift[g]) begin
                n_valid[g] = w_up_valid;
                n_exp[g]   = w_up_exp;
                n_own[g]   = w_up_own;
                n_tg[g]    = w_up_tg;
            end else if (i_cmd.insert && !w_le[g]) begin
                if (w_lo_le) begin
                    // new timer lands here
                    n_valid[g] = 1'b1;
                    n_exp[g]   = r_new_exp;
                    n_own[g]   = r_owner;
                    n_tg[g]    = r_tag;
                end else begin
                    n_valid[g] = w_lo_valid;
                    n_exp[g]   = w_lo_exp;
                    n_own[g]   = w_lo_own;
                    n_tg[g]    = w_lo_tg;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_exp[g] <= n_exp[g];
            r_own[g] <= n_own[g];
            r_tg[g]  <= n_tg[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grab_match) begin
            r_match <= w_match;
        end
    end

    // Status back to the controller
    assign w_head_wait       = r_exp[0] - r_now;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.full       = r_valid[TABLE_DEPTH-1];
    assign o_stat.any_match  = |r_match;
    assign o_stat.head_valid = r_valid[0];
    assign o_stat.head_due   = (r_exp[0] <= r_now);

    // Output register: holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind   <= i_cmd.kind;
            r_status <= i_cmd.status;
            r_last   <= i_cmd.last;
            r_fowner <= (i_cmd.kind == KIND_FIRED) ? r_own[0] : '0;
            r_ftag   <= (i_cmd.kind == KIND_FIRED) ? r_tg[0] : '0;
            r_wait   <= ((i_cmd.kind == KIND_WAIT) && r_valid[0]) ? w_head_wait : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_status      = r_status;
    assign o_fired_owner = r_fowner;
    assign o_fired_tag   = r_ftag;
    assign o_wait_ms     = r_wait;
    assign o_last        = r_last;

    // Occupied cells always form a contiguous run from slot 0
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_valid >> 1) & ~r_valid) == '0)
        else $error("occupied slots not contiguous");

    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result emitted over a stalled result");

    // Head pop only on an occupied, due head
    a_pop_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_valid[0] && (r_exp[0] <= r_now)))
        else $error("popped head that is empty or not due");

    // Insert never runs on a full table
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> !r_valid[TABLE_DEPTH-1])
        else $error("insert into a full table");

endmodule

@@ sv/sorted_timer_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_timer_queue_core
// Bounded timer table kept sorted by expiry; add, cancel and execute.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one request per transfer:
// add, cancel or execute. Output channel (o_out_valid / i_out_stall) carries
// result transfers; o_last marks the final result of a request.
// One request is worked on at a time; o_in_stall is high until the request's
// final result has been loaded into the output register. The next request is
// taken while that result still waits downstream.
// Steps from the input transfer to the result being loaded:
//   add     sorted insert over all cells in parallel (S_ADD)
//   cancel  register owner/tag matches (S_MATCH), then remove (S_CANCEL)
//   execute one head pop per due timer, each loading a fired result (one
//           head pop per cycle while the output is free), then the wait report
// Request code 3 is dropped with no result.
// When the receiver stalls, the output register holds its result and the
// sequencer waits before loading the next one; nothing is lost.
// Reset (synchronous, active low) empties the table and the output register
// at once; no clearing pass follows.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core
    import stq_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [TimeW-1:0]  i_now_ms,
    input  logic [TmoW-1:0]   i_timeout_ms,
    input  logic [OwnerW-1:0] i_owner_handle,
    input  logic [TagW-1:0]   i_timer_tag,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_result_kind,
    output logic              o_status,
    output logic [OwnerW-1:0] o_fired_owner,
    output logic [TagW-1:0]   o_fired_tag,
    output logic [TimeW-1:0]  o_wait_ms,
    output logic              o_last
);

    t_stq_cmd  w_cmd;
    t_stq_stat w_stat;

    // Sequencer
    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // Sorted cell row and output register
    stq_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_now_ms       (i_now_ms),
        .i_timeout_ms   (i_timeout_ms),
        .i_owner_handle (i_owner_handle),
        .i_timer_tag    (i_timer_tag),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_result_kind  (o_result_kind),
        .o_status       (o_status),
        .o_fired_owner  (o_fired_owner),
        .o_fired_tag    (o_fired_tag),
        .o_wait_ms      (o_wait_ms),
        .o_last         (o_last)
    );

endmodule
